@@ src/tlsb_pkg.sv @@
`default_nettype none

package tlsb_pkg;

  localparam int WORD_BITS   = 64;
  localparam int WORD_COUNT  = 64;
  localparam int POS_W       = $clog2(WORD_BITS);
  localparam int WIDX_W      = $clog2(WORD_COUNT);
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 12;
  localparam int COUNT_W     = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes as they arrive on the input channel.
  localparam logic [OP_W-1:0] OPC_SET   = 2'd0;
  localparam logic [OP_W-1:0] OPC_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OPC_GET   = 2'd2;

  typedef enum logic [1:0] {
    OPK_SET,
    OPK_CLEAR,
    OPK_GET
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [WIDX_W-1:0] word;
    logic [POS_W-1:0]  pos;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

endpackage

`default_nettype wire

@@ src/two_level_summary_bitmap.sv @@
// Two-level summary bitmap: a 4096-bit set held as 64 words of 64 bits, a
// summary word marking the non-empty words, and a count of set bits.
// Input channel (in_valid / in_stall): one word per operation, in_op selects
// set (0), clear (1) or get (2; the unused code also reads), in_bit_index
// picks the bit. A word is taken on a clock edge with in_valid high and
// in_stall low.
// Output channel (out_valid / out_stall): exactly one word per operation, in
// order, giving the bit's value before the operation and the count after it.
// An accepted word moves from the entry register into a two-deep queue, then
// takes a read step and an update step on the word store. The back end takes a
// new operation only once the last one is finished, as the single-port word
// store is read and then written for each operation.
// While out_stall is high the result is held and the back end waits; the
// queue and entry register keep taking words until they fill, then in_stall
// rises. Reset clears the summary, the count and the queues; the word store
// is not cleared, as its contents are only used while its summary bit is set.
`default_nettype none

module two_level_summary_bitmap (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tlsb_pkg::OP_W-1:0]     in_op,
  input  wire logic [tlsb_pkg::INDEX_W-1:0]  in_bit_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_bit_was_set,
  output logic [tlsb_pkg::COUNT_W-1:0]       out_set_count
);
  import tlsb_pkg::*;

  q_status_t q_status;
  item_t     push_item;
  item_t     head_item;
  logic      q_push;
  logic      q_pop;

  tlsb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_bit_index (in_bit_index),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  tlsb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .status    (q_status)
  );

  tlsb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .q_head          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bit_was_set (out_bit_was_set),
    .out_set_count   (out_set_count)
  );

endmodule

`default_nettype wire

@@ src/tlsb_front.sv @@
`default_nettype none

module tlsb_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tlsb_pkg::OP_W-1:0]   in_op,
  input  wire logic [tlsb_pkg::INDEX_W-1:0] in_bit_index,
  input  wire tlsb_pkg::q_status_t         q_status,
  output logic                             q_push,
  output tlsb_pkg::item_t                  q_item
);
  import tlsb_pkg::*;

  logic   front_valid_r;
  logic   front_valid_nxt;
  item_t  front_item_r;
  item_t  front_item_nxt;
  logic   in_take;

  assign q_push   = front_valid_r && !q_status.full;
  assign in_stall = front_valid_r && q_status.full;
  assign in_take  = in_valid && !in_stall;
  assign q_item   = front_item_r;

  // Unused operation codes behave as a read.
  always_comb begin
    unique case (in_op)
      OPC_SET:   front_item_nxt.kind = OPK_SET;
      OPC_CLEAR: front_item_nxt.kind = OPK_CLEAR;
      OPC_GET:   front_item_nxt.kind = OPK_GET;
      default:   front_item_nxt.kind = OPK_GET;
    endcase
    front_item_nxt.word = WIDX_W'((in_bit_index / WORD_BITS) % WORD_COUNT);
    front_item_nxt.pos  = POS_W'(in_bit_index % WORD_BITS);
  end

  assign front_valid_nxt = in_take || (front_valid_r && !q_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      front_item_r <= front_item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/tlsb_queue.sv @@
`default_nettype none

module tlsb_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire tlsb_pkg::item_t     push_item,
  input  wire logic                pop,
  output tlsb_pkg::item_t          head_item,
  output tlsb_pkg::q_status_t      status
);
  import tlsb_pkg::*;

  item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_item    = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ src/tlsb_back.sv @@
`default_nettype none

module tlsb_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tlsb_pkg::q_status_t           q_status,
  input  wire tlsb_pkg::item_t               q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_bit_was_set,
  output logic [tlsb_pkg::COUNT_W-1:0]       out_set_count
);
  import tlsb_pkg::*;

  back_state_t          state_r;
  back_state_t          state_nxt;
  item_t                item_r;
  logic [WORD_BITS-1:0] word_mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [WORD_COUNT-1:0] summary_r;
  logic [WORD_COUNT-1:0] summary_nxt;
  logic [COUNT_W-1:0]   population_r;
  logic [COUNT_W-1:0]   population_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_bit_was_set_r;
  logic [COUNT_W-1:0]   out_set_count_r;

  logic                 rd_en;
  logic                 wr_en;
  logic                 finish;
  logic                 slot_free;
  logic                 live;
  logic                 was;
  logic [WORD_BITS-1:0] bmask;
  logic [WORD_COUNT-1:0] wmask;
  logic [WORD_BITS-1:0] word_new;

  assign out_valid       = out_valid_r;
  assign out_bit_was_set = out_bit_was_set_r;
  assign out_set_count   = out_set_count_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign bmask     = {{(WORD_BITS-1){1'b0}}, 1'b1} << item_r.pos;
  assign wmask     = {{(WORD_COUNT-1){1'b0}}, 1'b1} << item_r.word;
  assign live      = summary_r[item_r.word];
  // A word whose summary bit is clear reads as empty whatever the store holds.
  assign was       = live && rd_data_r[item_r.pos];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_status.empty) state_nxt = BK_EXEC;
      BK_EXEC: if (slot_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop  = 1'b0;
    rd_en  = 1'b0;
    finish = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        q_pop = !q_status.empty;
        rd_en = !q_status.empty;
      end
      BK_EXEC: finish = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    word_new       = rd_data_r;
    wr_en          = 1'b0;
    summary_nxt    = summary_r;
    population_nxt = population_r;
    if (finish) begin
      case (item_r.kind)
        OPK_SET: begin
          if (!was) begin
            // An empty word is written fresh, so stale contents never leak in.
            word_new       = live ? (rd_data_r | bmask) : bmask;
            wr_en          = 1'b1;
            summary_nxt    = summary_r | wmask;
            population_nxt = population_r + COUNT_W'(1);
          end
        end
        OPK_CLEAR: begin
          if (was) begin
            word_new       = rd_data_r & ~bmask;
            wr_en          = 1'b1;
            population_nxt = population_r - COUNT_W'(1);
            if (word_new == '0) begin
              summary_nxt = summary_r & ~wmask;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = finish || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      summary_r    <= '0;
      population_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      summary_r    <= summary_nxt;
      population_r <= population_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_head;
    end
    if (finish) begin
      out_bit_was_set_r <= was;
      out_set_count_r   <= population_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= word_mem[q_head.word];
    end
    if (wr_en) begin
      word_mem[item_r.word] <= word_new;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_two_level_summary_bitmap.sv @@
`timescale 1ns / 100ps

module tb_two_level_summary_bitmap;
  import tlsb_pkg::*;

  // The spare operation code reads like a get and changes nothing.
  localparam logic [OP_W-1:0] OPC_SPARE = 2'd3;
  localparam int              MAX_INDEX = (1 << INDEX_W) - 1;
  localparam int              CYCLE_LIMIT = 200000;
  localparam int              PRINT_CAP = 100;

  typedef struct {
    logic               was_set;
    logic [COUNT_W-1:0] count;
  } bit_answer_t;

  class bitmap_scoreboard;
    logic [WORD_COUNT-1:0] live_words;
    logic [WORD_BITS-1:0]  bit_words [WORD_COUNT];
    logic [COUNT_W-1:0]    set_total;
    bit_answer_t           answer_queue[$];
    int                    mismatch_count;

    function new();
      live_words = '0;
      set_total = '0;
      mismatch_count = 0;
      foreach (bit_words[w]) bit_words[w] = '0;
    endfunction

    task report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Applies one accepted word to the shadow bitmap and queues its answer.
    function void note_accepted(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx);
      int unsigned wn;
      int unsigned pn;
      logic        live;
      logic        was;
      bit_answer_t ans;
      wn = (idx / WORD_BITS) % WORD_COUNT;
      pn = idx % WORD_BITS;
      live = live_words[wn];
      was = live && bit_words[wn][pn];
      case (op)
        OPC_SET: begin
          if (!live) begin
            live_words[wn] = 1'b1;
            bit_words[wn] = '0;
            bit_words[wn][pn] = 1'b1;
            set_total++;
          end else if (!was) begin
            bit_words[wn][pn] = 1'b1;
            set_total++;
          end
        end
        OPC_CLEAR: begin
          if (was) begin
            set_total--;
            bit_words[wn][pn] = 1'b0;
            if (bit_words[wn] == '0) live_words[wn] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      ans.was_set = was;
      ans.count = set_total;
      answer_queue.push_back(ans);
    endfunction

    task check_result(input logic was_set, input logic [COUNT_W-1:0] count);
      bit_answer_t ans;
      if (answer_queue.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding (was %b count %0d)",
                                  was_set, count));
      end else begin
        ans = answer_queue.pop_front();
        if (was_set !== ans.was_set)
          report_mismatch($sformatf("bit_was_set %b, predicted %b", was_set, ans.was_set));
        if (count !== ans.count)
          report_mismatch($sformatf("set_count %0d, predicted %0d", count, ans.count));
      end
    endtask

    function int outstanding();
      return answer_queue.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    in_op;
  logic [INDEX_W-1:0] in_bit_index;
  logic               out_valid;
  logic               out_stall;
  logic               out_bit_was_set;
  logic [COUNT_W-1:0] out_set_count;

  bitmap_scoreboard book;
  int               send_idle_pct;
  int               stall_pct;
  int               cycle_count;
  int               hot_words [3];

  two_level_summary_bitmap u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_bit_index    (in_bit_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bit_was_set (out_bit_was_set),
    .out_set_count   (out_set_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[two_level_summary_bitmap] ERROR");
      $finish;
    end
  end

  // Result side: sample at the rising edge, pick the next stall at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) book.check_result(out_bit_was_set, out_set_count);
      @(negedge clk);
      out_stall = rst_n && ($urandom_range(99) < stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_word(input logic [OP_W-1:0] op, input int idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op;
    in_bit_index = INDEX_W'(idx);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_accepted(op, INDEX_W'(idx));
    @(negedge clk);
  endtask

  // Fills one word completely, then empties it again in a scrambled order.
  task sweep_word(input int wn);
    int order [WORD_BITS];
    int j;
    int tmp;
    for (int p = 0; p < WORD_BITS; p++) begin
      send_word(OPC_SET, wn * WORD_BITS + p);
      order[p] = p;
    end
    for (int p = WORD_BITS - 1; p > 0; p--) begin
      j = $urandom_range(p);
      tmp = order[p];
      order[p] = order[j];
      order[j] = tmp;
    end
    for (int p = 0; p < WORD_BITS; p++) send_word(OPC_CLEAR, wn * WORD_BITS + order[p]);
  endtask

  // Most words land on a few busy bitmap words, and half of those on their
  // lowest bits, so that words fill up and empty out again often.
  task send_random(input int n);
    int               r;
    logic [OP_W-1:0]  op;
    int               idx;
    foreach (hot_words[k]) hot_words[k] = $urandom_range(WORD_COUNT - 1);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) op = OPC_SET;
      else if (r < 80) op = OPC_CLEAR;
      else if (r < 95) op = OPC_GET;
      else op = OPC_SPARE;
      if ($urandom_range(99) < 75) begin
        idx = hot_words[$urandom_range(2)] * WORD_BITS;
        idx += $urandom_range(1) ? $urandom_range(3) : $urandom_range(WORD_BITS - 1);
      end else begin
        idx = $urandom_range(MAX_INDEX);
      end
      send_word(op, idx);
    end
  endtask

  initial begin
    book = new();
    cycle_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OPC_GET;
    in_bit_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: index extremes, reads of empty words, no-op clears and
    // sets, a word emptied and refilled, and the spare code.
    send_word(OPC_SET, 0);
    send_word(OPC_SET, MAX_INDEX);
    send_word(OPC_GET, 0);
    send_word(OPC_GET, MAX_INDEX);
    send_word(OPC_GET, 100);
    send_word(OPC_CLEAR, 200);
    send_word(OPC_SET, 1);
    send_word(OPC_CLEAR, 2);
    send_word(OPC_SET, 1);
    send_word(OPC_CLEAR, 0);
    send_word(OPC_CLEAR, 1);
    send_word(OPC_GET, 1);
    send_word(OPC_SET, 63);
    send_word(OPC_SPARE, 63);
    send_word(OPC_SPARE, MAX_INDEX);
    send_word(OPC_CLEAR, MAX_INDEX);
    send_word(OPC_SET, 2048);
    send_word(OPC_GET, 2048);
    send_word(OPC_CLEAR, 63);
    send_word(OPC_GET, 63);
    send_word(OPC_SET, 1365);
    send_word(OPC_SET, 2730);

    send_random(170);

    send_idle_pct = 57;
    stall_pct = 0;
    send_random(170);

    send_idle_pct = 0;
    stall_pct = 57;
    sweep_word($urandom_range(WORD_COUNT - 1));
    send_random(170);

    send_idle_pct = 35;
    stall_pct = 35;
    send_random(170);
    in_valid = 1'b0;

    while (book.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.mismatch_count == 0) begin
      $display("[two_level_summary_bitmap] OK");
    end else begin
      $display("[two_level_summary_bitmap] ERROR");
    end
    $finish;
  end

endmodule

@@ two_level_summary_bitmap.f @@
src/tlsb_pkg.sv
src/tlsb_front.sv
src/tlsb_queue.sv
src/tlsb_back.sv
src/two_level_summary_bitmap.sv
dv/tb_two_level_summary_bitmap.sv
